// ===== design/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 20;
  localparam int ID_BITS      = 8;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // table update operations
  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_TAKE,
    TOP_SPLIT,
    TOP_FREE,
    TOP_MERGE
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e              op;
    logic [IDX_W-1:0]     idx;
    logic [ADDR_BITS-1:0] seg_end;
    logic [ID_BITS-1:0]   owner;
  } tbl_cmd_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] seg_end;
    logic [ID_BITS-1:0]   owner;
    logic                 free;
    logic [CNT_W-1:0]     count;
  } tbl_rd_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] region_start;
    logic [ADDR_BITS-1:0] region_end;
  } ffpa_res_t;

endpackage

`default_nettype wire

// ===== design/first_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// First-fit variable partition allocator with coalescing of freed regions.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. It then walks the segment
// table from entry 1 upwards, one entry per cycle through a single subtract
// and compare unit. A zero-size allocate is answered without the walk, a
// request that matches no entry spends one more step at the end of the
// table, and a release that matches takes two more steps for the merges
// with its neighbours. A result waits in the sequencer until the output
// register is free. A finished result sits in the output register while
// the next request is taken. Writing memory_size or system_size rebuilds
// the table as after reset.
`default_nettype none

module first_fit_partition_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave side: tdata = process_id[7:0], request_size[27:8], zero pad [31:28]
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,
  // tuser = kind[0]
  input  wire  [0:0]  s_tuser,
  // master side: tdata = status[1:0], region_start[21:2], region_end[41:22],
  // zero pad [47:42]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = ffpa_pkg::ADDR_BITS;
  localparam int IW = ffpa_pkg::ID_BITS;

  logic [AW-1:0] mem_size_q, mem_size_d;
  logic [AW-1:0] sys_size_q, sys_size_d;
  logic          cfg_wr;

  logic          out_valid_q;
  logic [47:0]   out_data_q;
  logic          res_ready;

  ffpa_pkg::ffpa_res_t res;
  ffpa_pkg::tbl_rd_t   rd;
  ffpa_pkg::tbl_cmd_t  cmd;
  logic [ffpa_pkg::IDX_W-1:0] rd_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    mem_size_d = mem_size_q;
    sys_size_d = sys_size_q;
    if (cfg_wr) begin
      if (!paddr[2]) begin
        mem_size_d = pwdata[AW-1:0];
      end else begin
        sys_size_d = pwdata[AW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(sys_size_q) : 32'(mem_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= AW'(1024);
      sys_size_q <= AW'(64);
    end else begin
      mem_size_q <= mem_size_d;
      sys_size_q <= sys_size_d;
    end
  end

  ffpa_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (cfg_wr),
    .init_mem_i (mem_size_d),
    .init_sys_i (sys_size_d),
    .rd_idx_i   (rd_idx),
    .cmd_i      (cmd),
    .rd_o       (rd)
  );

  // output register frees once its transfer completes
  assign res_ready = !out_valid_q || m_tready;

  ffpa_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_tvalid),
    .req_ready_o    (s_tready),
    .kind_i         (s_tuser[0]),
    .process_id_i   (s_tdata[IW-1:0]),
    .request_size_i (s_tdata[IW+AW-1:IW]),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .rd_i           (rd),
    .rd_idx_o       (rd_idx),
    .cmd_o          (cmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= {6'b0, res.region_end, res.region_start, res.status};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== design/ffpa_table.sv =====
// ----------------------------------------------------------------------------
// ffpa_table
// Address-ordered segment table with one read port and whole-table
// insert and remove shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_table (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             init_i,
  input  wire [ffpa_pkg::ADDR_BITS-1:0]   init_mem_i,
  input  wire [ffpa_pkg::ADDR_BITS-1:0]   init_sys_i,
  input  wire [ffpa_pkg::IDX_W-1:0]       rd_idx_i,
  input  ffpa_pkg::tbl_cmd_t              cmd_i,
  output ffpa_pkg::tbl_rd_t               rd_o
);

  localparam int N = ffpa_pkg::MAX_SEGMENTS;
  localparam int AW = ffpa_pkg::ADDR_BITS;
  localparam int IW = ffpa_pkg::ID_BITS;
  localparam int XW = ffpa_pkg::IDX_W;
  localparam int CW = ffpa_pkg::CNT_W;

  logic [AW-1:0] end_q   [N];
  logic [AW-1:0] end_d   [N];
  logic [IW-1:0] owner_q [N];
  logic [IW-1:0] owner_d [N];
  logic [N-1:0]  free_q, free_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      end_d[k]   = end_q[k];
      owner_d[k] = owner_q[k];
      free_d[k]  = free_q[k];
    end
    count_d = count_q;
    case (cmd_i.op)
      ffpa_pkg::TOP_TAKE: begin
        for (int k = 0; k < N; k++) begin
          if (XW'(k) == cmd_i.idx) begin
            free_d[k]  = 1'b0;
            owner_d[k] = cmd_i.owner;
          end
        end
      end
      ffpa_pkg::TOP_SPLIT: begin
        // open a slot at idx, everything above moves up by one
        for (int k = 0; k < N; k++) begin
          if (XW'(k) == cmd_i.idx) begin
            end_d[k]   = cmd_i.seg_end;
            owner_d[k] = cmd_i.owner;
            free_d[k]  = 1'b0;
          end else if (k > 0 && XW'(k) > cmd_i.idx) begin
            end_d[k]   = end_q[k-1];
            owner_d[k] = owner_q[k-1];
            free_d[k]  = free_q[k-1];
          end
        end
        count_d = count_q + 1'b1;
      end
      ffpa_pkg::TOP_FREE: begin
        for (int k = 0; k < N; k++) begin
          if (XW'(k) == cmd_i.idx) begin
            free_d[k]  = 1'b1;
            owner_d[k] = '0;
          end
        end
      end
      ffpa_pkg::TOP_MERGE: begin
        // lower neighbour absorbs entry idx, which is then removed
        for (int k = 0; k < N; k++) begin
          if (XW'(k + 1) == cmd_i.idx) begin
            end_d[k] = cmd_i.seg_end;
          end else if (XW'(k) >= cmd_i.idx) begin
            if (k + 1 < N) begin
              end_d[k]   = end_q[(k + 1) % N];
              owner_d[k] = owner_q[(k + 1) % N];
              free_d[k]  = free_q[(k + 1) % N];
            end else begin
              end_d[k]   = '0;
              owner_d[k] = '0;
              free_d[k]  = 1'b0;
            end
          end
        end
        count_d = count_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (init_i) begin
      for (int k = 0; k < N; k++) begin
        end_d[k]   = '0;
        owner_d[k] = '0;
        free_d[k]  = 1'b0;
      end
      end_d[0]  = init_sys_i;
      end_d[1]  = init_mem_i;
      free_d[1] = 1'b1;
      count_d   = CW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        end_q[k]   <= '0;
        owner_q[k] <= '0;
      end
      end_q[0] <= AW'(64);
      end_q[1] <= AW'(1024);
      free_q   <= N'(2);
      count_q  <= CW'(2);
    end else begin
      for (int k = 0; k < N; k++) begin
        end_q[k]   <= end_d[k];
        owner_q[k] <= owner_d[k];
      end
      free_q  <= free_d;
      count_q <= count_d;
    end
  end

  assign rd_o.seg_end = end_q[rd_idx_i];
  assign rd_o.owner   = owner_q[rd_idx_i];
  assign rd_o.free    = free_q[rd_idx_i];
  assign rd_o.count   = count_q;

endmodule

`default_nettype wire

// ===== design/ffpa_seq.sv =====
// ----------------------------------------------------------------------------
// ffpa_seq
// Request sequencer: walks the table one entry a cycle through a shared
// subtract and compare unit, then issues split, take, free and merge steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_seq (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             req_valid_i,
  output logic                            req_ready_o,
  input  wire                             kind_i,
  input  wire [ffpa_pkg::ID_BITS-1:0]     process_id_i,
  input  wire [ffpa_pkg::ADDR_BITS-1:0]   request_size_i,
  input  wire                             res_ready_i,
  output ffpa_pkg::ffpa_res_t             res_o,
  input  ffpa_pkg::tbl_rd_t               rd_i,
  output logic [ffpa_pkg::IDX_W-1:0]      rd_idx_o,
  output ffpa_pkg::tbl_cmd_t              cmd_o
);

  localparam int AW = ffpa_pkg::ADDR_BITS;
  localparam int IW = ffpa_pkg::ID_BITS;
  localparam int XW = ffpa_pkg::IDX_W;
  localparam int CW = ffpa_pkg::CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RNEXT = 3'd2;
  localparam logic [2:0] S_RPREV = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] start_q, start_d;
  logic          kind_q, kind_d;
  logic [IW-1:0] pid_q, pid_d;
  logic [AW-1:0] size_q, size_d;
  logic          prev_free_q, prev_free_d;
  logic [1:0]    st_q, st_d;
  logic [AW-1:0] rs_q, rs_d;
  logic [AW-1:0] re_q, re_d;

  // shared unit: segment length and fit compare
  logic [AW:0]   diff;
  logic          in_range;
  logic          fits;
  logic          exact;
  logic [AW-1:0] split_end;

  assign diff      = {1'b0, rd_i.seg_end} - {1'b0, start_q};
  assign in_range  = idx_q < rd_i.count;
  assign fits      = rd_i.free && !diff[AW] && (diff[AW-1:0] >= size_q);
  assign exact     = diff[AW-1:0] == size_q;
  assign split_end = start_q + size_q;

  assign rd_idx_o    = idx_q[XW-1:0];
  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    start_d     = start_q;
    kind_d      = kind_q;
    pid_d       = pid_q;
    size_d      = size_q;
    prev_free_d = prev_free_q;
    st_d        = st_q;
    rs_d        = rs_q;
    re_d        = re_q;
    cmd_o.op      = ffpa_pkg::TOP_NONE;
    cmd_o.idx     = idx_q[XW-1:0];
    cmd_o.seg_end = rd_i.seg_end;
    cmd_o.owner   = pid_q;
    res_o.valid        = 1'b0;
    res_o.status       = st_q;
    res_o.region_start = rs_q;
    res_o.region_end   = re_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          kind_d      = kind_i;
          pid_d       = process_id_i;
          size_d      = request_size_i;
          start_d     = rd_i.seg_end;   // end of the system region
          prev_free_d = 1'b0;
          idx_d       = CW'(1);
          if (kind_i == ffpa_pkg::KIND_ALLOC && request_size_i == '0) begin
            st_d    = ffpa_pkg::ST_NO_FIT;
            rs_d    = '0;
            re_d    = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!in_range) begin
          st_d    = (kind_q == ffpa_pkg::KIND_ALLOC) ? ffpa_pkg::ST_NO_FIT
                                                     : ffpa_pkg::ST_UNKNOWN;
          rs_d    = '0;
          re_d    = '0;
          state_d = S_DONE;
        end else if (kind_q == ffpa_pkg::KIND_ALLOC) begin
          if (fits) begin
            state_d = S_DONE;
            if (exact) begin
              cmd_o.op = ffpa_pkg::TOP_TAKE;
              st_d     = ffpa_pkg::ST_DONE;
              rs_d     = start_q;
              re_d     = rd_i.seg_end;
            end else if (rd_i.count == CW'(ffpa_pkg::MAX_SEGMENTS)) begin
              st_d = ffpa_pkg::ST_FULL;
              rs_d = '0;
              re_d = '0;
            end else begin
              cmd_o.op      = ffpa_pkg::TOP_SPLIT;
              cmd_o.seg_end = split_end;
              st_d          = ffpa_pkg::ST_DONE;
              rs_d          = start_q;
              re_d          = split_end;
            end
          end else begin
            start_d = rd_i.seg_end;
            idx_d   = idx_q + 1'b1;
          end
        end else begin
          if (!rd_i.free && rd_i.owner == pid_q) begin
            cmd_o.op = ffpa_pkg::TOP_FREE;
            st_d     = ffpa_pkg::ST_DONE;
            rs_d     = start_q;
            re_d     = rd_i.seg_end;
            idx_d    = idx_q + 1'b1;
            state_d  = S_RNEXT;
          end else begin
            start_d     = rd_i.seg_end;
            prev_free_d = rd_i.free;
            idx_d       = idx_q + 1'b1;
          end
        end
      end
      S_RNEXT: begin
        // upper neighbour free: freed entry takes its end, neighbour removed
        if (in_range && rd_i.free) begin
          cmd_o.op = ffpa_pkg::TOP_MERGE;
        end
        idx_d   = idx_q - 1'b1;
        state_d = S_RPREV;
      end
      S_RPREV: begin
        if (prev_free_q) begin
          cmd_o.op = ffpa_pkg::TOP_MERGE;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          res_o.valid = 1'b1;
          idx_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        idx_d   = '0;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      prev_free_q <= 1'b0;
      kind_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      prev_free_q <= prev_free_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    pid_q   <= pid_d;
    size_q  <= size_d;
    st_q    <= st_d;
    rs_q    <= rs_d;
    re_q    <= re_d;
  end

endmodule

`default_nettype wire
